/* rtl/bd_pkg.sv */
// -----------------------------------------------------------------------------
// bd_pkg
// Shared types and constants of the fraction-free determinant engine.
// -----------------------------------------------------------------------------
package bd_pkg;

   localparam int DATA_BITS = 64;
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int MUL_STEPS = 4;
   localparam int DIV_STEPS = PROD_BITS;

   // register map
   localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
   localparam logic [2:0] SIZE_RESET      = 3'd4;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_PIVOT = 2'd1,
      ST_OVERFLOW   = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       load_wr;
      logic       cell_wr;
      logic       rd_en;
      logic       cap_a;
      logic       cap_b;
      logic       cap_den;
      logic       den_one;
      logic       mul_clear;
      logic       pp_en;
      logic [1:0] pp_sel;
      logic       acc_en;
      logic       form_p1;
      logic       form_diff;
      logic       div_init;
      logic       div_step;
      logic       cap_det;
      logic       out_load;
      status_type out_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic den_zero;
      logic q_ovf;
      logic out_free;
   } dp_stat_type;

endpackage

/* rtl/bd_if.sv */
// -----------------------------------------------------------------------------
// bd_req_if / bd_rsp_if
// Valid/ready channels carrying matrix entries in and determinants out.
// -----------------------------------------------------------------------------
interface bd_req_if #(parameter int ENTRY_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [ENTRY_BITS-1:0] entry_value;

   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface

interface bd_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [63:0] determinant;
   logic [1:0]         status;

   modport source (output valid, output determinant, output status, input ready);
   modport sink   (input valid, input determinant, input status, output ready);
endinterface

/* rtl/bd_ctrl.sv */
// -----------------------------------------------------------------------------
// bd_ctrl
// Sequencer: load counting, elimination loop indices and cell micro-steps.
// -----------------------------------------------------------------------------
module bd_ctrl #(
   parameter int MAX_ORDER  = 4,
   parameter int ADDR_BITS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             matrix_size,
   input  logic                   size_wr,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bd_pkg::dp_stat_type    stat,
   output bd_pkg::dp_cmd_type     cmd,
   output logic [ADDR_BITS-1:0]   rd_addr,
   output logic [ADDR_BITS-1:0]   wr_addr
);
   import bd_pkg::*;

   localparam int IDX_BITS   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ORD_BITS   = $clog2(MAX_ORDER + 1);
   localparam int CNT_BITS   = $clog2(MAX_ORDER * MAX_ORDER + 1);
   localparam int DCNT_BITS  = $clog2(DIV_STEPS);

   typedef enum logic [15:0] {
      S_LOAD   = 16'h0001,
      S_RDDEN  = 16'h0002,
      S_CAPDEN = 16'h0004,
      S_RDA    = 16'h0008,
      S_RDB    = 16'h0010,
      S_CAPB   = 16'h0020,
      S_MUL    = 16'h0040,
      S_PRD    = 16'h0080,
      S_RDC    = 16'h0100,
      S_RDD    = 16'h0200,
      S_DIVI   = 16'h0400,
      S_DIV    = 16'h0800,
      S_WR     = 16'h1000,
      S_FIN    = 16'h2000,
      S_FCAP   = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  load_cnt_ff, load_cnt_in;
   logic [IDX_BITS-1:0]  k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [2:0]           mcnt_ff, mcnt_in;
   logic [DCNT_BITS-1:0] dcnt_ff, dcnt_in;
   logic                 pass_ff, pass_in;
   status_type           err_ff, err_in;

   logic [ORD_BITS-1:0]  order;
   logic [IDX_BITS-1:0]  nm1, km1;
   logic [CNT_BITS-1:0]  total;
   logic                 accept;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [IDX_BITS-1:0] r,
                                                      input logic [IDX_BITS-1:0] c,
                                                      input logic [ORD_BITS-1:0] n);
      return ADDR_BITS'(int'(r) * int'(n) + int'(c));
   endfunction

   // saturate the size register into a usable order
   always_comb begin
      if (matrix_size == 3'd0) begin
         order = ORD_BITS'(1);
      end else if ({1'b0, matrix_size} > 4'(MAX_ORDER)) begin
         order = ORD_BITS'(MAX_ORDER);
      end else begin
         order = ORD_BITS'(matrix_size);
      end
   end

   assign nm1    = IDX_BITS'(order - ORD_BITS'(1));
   assign km1    = (k_ff == '0) ? '0 : k_ff - IDX_BITS'(1);
   assign total  = CNT_BITS'(int'(order) * int'(order));
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_LOAD);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      mcnt_in     = mcnt_ff;
      dcnt_in     = dcnt_ff;
      pass_in     = pass_ff;
      err_in      = err_ff;
      cmd         = '0;
      cmd.out_status = err_ff;
      rd_addr     = cell_addr(i_ff, j_ff, order);
      wr_addr     = load_cnt_ff[ADDR_BITS-1:0];

      case (state_ff)
         S_LOAD: begin
            cmd.load_wr = accept;
            if (size_wr) begin
               load_cnt_in = '0;
            end else if (accept) begin
               if (load_cnt_ff + CNT_BITS'(1) == total) begin
                  load_cnt_in = '0;
                  err_in      = ST_OK;
                  k_in        = '0;
                  i_in        = IDX_BITS'(1);
                  j_in        = IDX_BITS'(1);
                  state_in    = (order == ORD_BITS'(1)) ? S_FIN : S_RDDEN;
               end else begin
                  load_cnt_in = load_cnt_ff + CNT_BITS'(1);
               end
            end
         end
         S_RDDEN: begin
            cmd.rd_en = 1'b1;
            rd_addr   = cell_addr(km1, km1, order);
            state_in  = S_CAPDEN;
         end
         S_CAPDEN: begin
            cmd.cap_den = 1'b1;
            cmd.den_one = (k_ff == '0);
            state_in    = S_RDA;
         end
         S_RDA: begin
            pass_in = 1'b0;
            if (stat.den_zero) begin
               err_in   = ST_ZERO_PIVOT;
               state_in = S_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = cell_addr(i_ff, j_ff, order);
               state_in  = S_RDB;
            end
         end
         S_RDB: begin
            cmd.cap_a = 1'b1;
            cmd.rd_en = 1'b1;
            rd_addr   = cell_addr(k_ff, k_ff, order);
            state_in  = S_CAPB;
         end
         S_CAPB: begin
            cmd.cap_b     = 1'b1;
            cmd.mul_clear = 1'b1;
            mcnt_in       = '0;
            state_in      = S_MUL;
         end
         // four partial products, each accumulated in the following cycle
         S_MUL: begin
            cmd.pp_en  = (mcnt_ff < 3'(MUL_STEPS));
            cmd.pp_sel = mcnt_ff[1:0];
            cmd.acc_en = (mcnt_ff != 3'd0);
            mcnt_in    = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'(MUL_STEPS)) begin
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            if (!pass_ff) begin
               cmd.form_p1 = 1'b1;
               pass_in     = 1'b1;
               state_in    = S_RDC;
            end else begin
               cmd.form_diff = 1'b1;
               state_in      = S_DIVI;
            end
         end
         S_RDC: begin
            cmd.rd_en = 1'b1;
            rd_addr   = cell_addr(i_ff, k_ff, order);
            state_in  = S_RDD;
         end
         S_RDD: begin
            cmd.cap_a = 1'b1;
            cmd.rd_en = 1'b1;
            rd_addr   = cell_addr(k_ff, j_ff, order);
            state_in  = S_CAPB;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + DCNT_BITS'(1);
            if (dcnt_ff == DCNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_WR;
            end
         end
         // store the quotient, or flag an overflow, and advance j, i, then k
         S_WR: begin
            wr_addr = cell_addr(i_ff, j_ff, order);
            if (stat.q_ovf) begin
               err_in   = ST_OVERFLOW;
               state_in = S_OUT;
            end else begin
               cmd.cell_wr = 1'b1;
               state_in    = S_RDDEN;
               if (j_ff < nm1) begin
                  j_in = j_ff + IDX_BITS'(1);
               end else if (i_ff < nm1) begin
                  i_in = i_ff + IDX_BITS'(1);
                  j_in = k_ff + IDX_BITS'(1);
               end else if (k_ff + IDX_BITS'(1) < nm1) begin
                  k_in = k_ff + IDX_BITS'(1);
                  i_in = k_ff + IDX_BITS'(2);
                  j_in = k_ff + IDX_BITS'(2);
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            cmd.rd_en = 1'b1;
            rd_addr   = cell_addr(nm1, nm1, order);
            state_in  = S_FCAP;
         end
         S_FCAP: begin
            cmd.cap_det = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= '0;
         err_ff      <= ST_OK;
         pass_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         err_ff      <= err_in;
         pass_ff     <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      mcnt_ff <= mcnt_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

/* rtl/bd_dp.sv */
// -----------------------------------------------------------------------------
// bd_dp
// Matrix memory, split 64x64 multiplier, 128/64 restoring divider, result word.
// -----------------------------------------------------------------------------
module bd_dp #(
   parameter int MAX_ORDER  = 4,
   parameter int ENTRY_BITS = 16,
   parameter int ADDR_BITS  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bd_pkg::dp_cmd_type            cmd,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic signed [ENTRY_BITS-1:0]  entry_value,
   output bd_pkg::dp_stat_type           stat,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [63:0]            determinant,
   output logic [1:0]                    status
);
   import bd_pkg::*;

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int HALF  = DATA_BITS / 2;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_q_ff;
   logic [DATA_BITS-1:0] opa_ff, opb_ff, d_ff, det_ff;
   logic                 sa_ff, sb_ff, dsgn_ff, qsign_ff;
   logic [DATA_BITS-1:0] pp_ff;
   logic [1:0]           psh_ff;
   logic [PROD_BITS-1:0] acc_ff;
   logic [PROD_BITS:0]   p1_ff;
   logic [PROD_BITS-1:0] qd_ff;
   logic [DATA_BITS-1:0] rem_ff;
   logic                 rsp_valid_ff;
   logic [DATA_BITS-1:0] rsp_det_ff;
   logic [1:0]           rsp_status_ff;

   logic [DATA_BITS-1:0] entry_ext, wr_data, rd_mag, qval;
   logic [HALF-1:0]      mx, my;
   logic [PROD_BITS-1:0] pp_shift;
   logic [PROD_BITS:0]   acc_ext;
   logic                 psign;
   logic [DATA_BITS:0]   rem_sh, rem_sub;
   logic                 ge;

   assign entry_ext = {{(DATA_BITS - ENTRY_BITS){entry_value[ENTRY_BITS-1]}}, entry_value};
   assign rd_mag    = rd_q_ff[DATA_BITS-1] ? (~rd_q_ff + DATA_BITS'(1)) : rd_q_ff;
   assign qval      = qsign_ff ? (~qd_ff[DATA_BITS-1:0] + DATA_BITS'(1))
                               : qd_ff[DATA_BITS-1:0];
   assign wr_data   = cmd.load_wr ? entry_ext : qval;

   // matrix memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_wr || cmd.cell_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // operand magnitudes and signs
   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         opa_ff <= rd_mag;
         sa_ff  <= rd_q_ff[DATA_BITS-1];
      end
      if (cmd.cap_b) begin
         opb_ff <= rd_mag;
         sb_ff  <= rd_q_ff[DATA_BITS-1];
      end
      if (cmd.cap_den) begin
         d_ff    <= cmd.den_one ? DATA_BITS'(1) : rd_mag;
         dsgn_ff <= cmd.den_one ? 1'b0 : rd_q_ff[DATA_BITS-1];
      end
      if (cmd.cap_det) begin
         det_ff <= rd_q_ff;
      end
   end

   // one 32x32 partial product per cycle, added in the next
   assign mx = cmd.pp_sel[1] ? opa_ff[DATA_BITS-1:HALF] : opa_ff[HALF-1:0];
   assign my = cmd.pp_sel[0] ? opb_ff[DATA_BITS-1:HALF] : opb_ff[HALF-1:0];

   always_comb begin
      case (psh_ff)
         2'd0:    pp_shift = PROD_BITS'(pp_ff);
         2'd3:    pp_shift = PROD_BITS'(pp_ff) << DATA_BITS;
         default: pp_shift = PROD_BITS'(pp_ff) << HALF;
      endcase
   end

   assign psign   = sa_ff ^ sb_ff;
   assign acc_ext = {1'b0, acc_ff};

   always_ff @(posedge clock) begin
      if (cmd.pp_en) begin
         pp_ff  <= DATA_BITS'(mx) * DATA_BITS'(my);
         psh_ff <= cmd.pp_sel;
      end
      if (cmd.mul_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + pp_shift;
      end
      if (cmd.form_p1) begin
         p1_ff <= psign ? (~acc_ext + (PROD_BITS+1)'(1)) : acc_ext;
      end else if (cmd.form_diff) begin
         p1_ff <= psign ? (p1_ff + acc_ext) : (p1_ff - acc_ext);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh  = {rem_ff, qd_ff[PROD_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, d_ff};
   assign ge      = (rem_sh >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         qd_ff    <= p1_ff[PROD_BITS] ? PROD_BITS'(~p1_ff + (PROD_BITS+1)'(1))
                                      : p1_ff[PROD_BITS-1:0];
         qsign_ff <= p1_ff[PROD_BITS] ^ dsgn_ff;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? rem_sub[DATA_BITS-1:0] : rem_sh[DATA_BITS-1:0];
         qd_ff  <= {qd_ff[PROD_BITS-2:0], ge};
      end
   end

   assign stat.den_zero = (d_ff == '0);
   assign stat.q_ovf    = (qd_ff[PROD_BITS-1:DATA_BITS] != '0)
                       || (!qsign_ff && qd_ff[DATA_BITS-1])
                       || (qsign_ff && qd_ff[DATA_BITS-1] && (qd_ff[DATA_BITS-2:0] != '0));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // result word, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_det_ff    <= (cmd.out_status == ST_OK) ? det_ff : '0;
         rsp_status_ff <= cmd.out_status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign determinant = rsp_det_ff;
   assign status      = rsp_status_ff;

endmodule

/* rtl/bareiss_determinant.sv */
// -----------------------------------------------------------------------------
// bareiss_determinant
// Loads an n x n integer matrix word by word and returns its exact determinant.
// -----------------------------------------------------------------------------
//  channel | direction | payload
//  req_ch  | in        | entry_value, one matrix entry per word, row-major
//  rsp_ch  | out       | determinant, status, one word per matrix
//  psel..  | cfg (APB) | matrix_size at byte address 0
//
//  Loading accepts one entry per cycle. After the last entry each Bareiss cell
//  update runs the 128-step restoring divider and two split multiplies; an
//  n x n matrix needs (n-1)n(2n-1)/6 updates. Reset is synchronous; no words
//  are accepted while a determinant is computed. A result waiting on rsp_ch
//  stalls only the end of the following computation.
// -----------------------------------------------------------------------------
module bareiss_determinant #(
   parameter int MAX_ORDER  = 4,
   parameter int ENTRY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   bd_req_if.sink      req_ch,
   bd_rsp_if.source    rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bd_pkg::*;

   localparam int ADDR_BITS = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;

   logic [2:0]           size_ff;
   logic                 size_wr;
   dp_cmd_type           cmd;
   dp_stat_type          stat;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;

   // configuration register
   assign pready  = 1'b1;
   assign size_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_MATRIX_SIZE);
   assign prdata  = (paddr[2:2] == REG_MATRIX_SIZE) ? {29'd0, size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (size_wr) begin
         size_ff <= pwdata[2:0];
      end
   end

   bd_ctrl #(
      .MAX_ORDER (MAX_ORDER),
      .ADDR_BITS (ADDR_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .matrix_size (size_ff),
      .size_wr     (size_wr),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .stat        (stat),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr)
   );

   bd_dp #(
      .MAX_ORDER  (MAX_ORDER),
      .ENTRY_BITS (ENTRY_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .entry_value (req_ch.entry_value),
      .stat        (stat),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .determinant (rsp_ch.determinant),
      .status      (rsp_ch.status)
   );

endmodule
